@@ hw/rtl/vna_pkg.sv @@
// ---------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal averager.
// ---------------------------------------------------------------------------
package vna_pkg;

    localparam int IDX_W     = 10;
    localparam int POS_W     = 24;
    localparam int NRM_W     = 16;
    localparam int DEF_VERTS = 1024;
    localparam int DEF_SUM_W = 24;
    localparam int IN_W      = 2 + 3 * IDX_W + 3 * POS_W;
    localparam int IN_BYTES  = (IN_W + 7) / 8;
    localparam int OUT_W     = 3 * NRM_W;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

endpackage

@@ hw/rtl/vertex_normal_averager_core.sv @@
// ---------------------------------------------------------------------------
// vertex_normal_averager_core
// Per-vertex normal averager over a position memory and a sum memory.
// ---------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// s_axis    in   operation, vertex_index, second_index, third_index,
//                pos_x, pos_y, pos_z
// m_axis    out  tdata: normal_x, normal_y, normal_z; tuser: zero_sum
//
// One item is in work at a time. After its transfer, the time of a read or a
// triangle is set mostly by the bit-serial square root, the restoring divider
// (run once per component) and the alignment shifts; a zero sum or a zero
// area skips these steps. Sums are cleared after reset by a sweep over all
// MAX_VERTICES entries in which no item is accepted. A result waits in the
// output register while tready is low; the next item is still taken and
// stalls only when its own result is ready.
// ---------------------------------------------------------------------------
module vertex_normal_averager_core #(
    parameter int MAX_VERTICES = vna_pkg::DEF_VERTS,
    parameter int SUM_WIDTH    = vna_pkg::DEF_SUM_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation, vertex_index, second_index, third_index, pos_x, pos_y, pos_z
    input  logic [vna_pkg::IN_BYTES*8-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [vna_pkg::OUT_W-1:0]         m_axis_tdata,
    // zero_sum
    output logic                              m_axis_tuser
);
    import vna_pkg::*;

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int MW  = 64;

    typedef enum logic [16:0] {
        S_CLR   = 17'h00001, S_IDLE  = 17'h00002, S_RDA   = 17'h00004,
        S_RDB   = 17'h00008, S_RDC   = 17'h00010, S_EDGE  = 17'h00020,
        S_MUL   = 17'h00040, S_CROSS = 17'h00080, S_MAG   = 17'h00100,
        S_SHFT  = 17'h00200, S_SQ    = 17'h00400, S_SQRT  = 17'h00800,
        S_DIV   = 17'h01000, S_SUMRD = 17'h02000, S_SUMWR = 17'h04000,
        S_OUT   = 17'h08000, S_RDS   = 17'h10000
    } t_state;

    t_state r_state;

    logic [POS_W*3-1:0]      r_pos_mem [MAX_VERTICES];
    logic [SUM_WIDTH*3-1:0]  r_sum_mem [MAX_VERTICES];
    logic [POS_W*3-1:0]      r_pos_q;
    logic [SUM_WIDTH*3-1:0]  r_sum_q;

    logic                    pos_we, sum_we;
    logic [AW-1:0]           pos_wa, pos_ra, sum_wa, sum_ra;
    logic [POS_W*3-1:0]      pos_wd;
    logic [SUM_WIDTH*3-1:0]  sum_wd;

    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos_mem[pos_wa] <= pos_wd;
        r_pos_q <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_wa] <= sum_wd;
        r_sum_q <= r_sum_mem[sum_ra];
    end

    // Input fields.
    t_op                 in_op;
    logic [IDX_W-1:0]    in_ia, in_ib, in_ic;
    logic [POS_W*3-1:0]  in_pos;
    assign in_op  = t_op'(s_axis_tdata[1:0]);
    assign in_ia  = s_axis_tdata[2 +: IDX_W];
    assign in_ib  = s_axis_tdata[2+IDX_W +: IDX_W];
    assign in_ic  = s_axis_tdata[2+2*IDX_W +: IDX_W];
    assign in_pos = s_axis_tdata[2+3*IDX_W +: 3*POS_W];

    logic in_xfer, out_xfer;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    logic             r_tri;
    logic [AW-1:0]    r_idx [3];
    logic [AW:0]      r_cnt;
    logic [5:0]       r_dcnt;
    logic [1:0]       r_k;
    logic signed [POS_W:0]    r_va [3];
    logic signed [POS_W:0]    r_e1 [3], r_e2 [3];
    logic signed [2*POS_W+1:0] r_p [6];
    logic signed [MW-1:0]     r_c [3];
    logic [MW-1:0]            r_m [3];
    logic [MW-1:0]            r_sq, r_rem, r_root, r_bit;
    logic [MW-1:0]            r_len, r_dv;
    logic [NRM_W:0]           r_q;
    logic signed [NRM_W-1:0]  r_n [3];
    logic                     r_ok;
    logic [POS_W*3-1:0]       r_pb;

    logic ok_a, ok_b, ok_c;
    assign ok_a = ({1'b0, in_ia} < (IDX_W+1)'(MAX_VERTICES)) || (MAX_VERTICES > 1023);
    assign ok_b = ({1'b0, in_ib} < (IDX_W+1)'(MAX_VERTICES)) || (MAX_VERTICES > 1023);
    assign ok_c = ({1'b0, in_ic} < (IDX_W+1)'(MAX_VERTICES)) || (MAX_VERTICES > 1023);

    function automatic logic signed [POS_W:0] pcomp(logic [POS_W*3-1:0] v, int i);
        pcomp = {v[i*POS_W+POS_W-1], v[i*POS_W +: POS_W]};
    endfunction

    function automatic logic signed [MW-1:0] scomp(logic [SUM_WIDTH*3-1:0] v, int i);
        scomp = MW'($signed(v[i*SUM_WIDTH +: SUM_WIDTH]));
    endfunction

    localparam logic signed [MW-1:0] S_HI = MW'((64'sd1 <<< (SUM_WIDTH-1)) - 1);
    localparam logic signed [MW-1:0] S_LO = -S_HI - 1;

    logic signed [SUM_WIDTH-1:0] sat_v [3];
    always_comb begin
        logic signed [MW-1:0] s;
        for (int i = 0; i < 3; i++) begin
            s = scomp(r_sum_q, i) + MW'(r_n[i]);
            if (s > S_HI) s = S_HI;
            if (s < S_LO) s = S_LO;
            sat_v[i] = s[SUM_WIDTH-1:0];
        end
    end

    logic [MW-1:0] big;
    assign big = (r_m[0] > r_m[1]) ? ((r_m[0] > r_m[2]) ? r_m[0] : r_m[2])
                                   : ((r_m[1] > r_m[2]) ? r_m[1] : r_m[2]);

    // Magnitudes are below 2^30 once aligned.
    logic [59:0] sq_p [3];
    assign sq_p[0] = r_m[0][29:0] * r_m[0][29:0];
    assign sq_p[1] = r_m[1][29:0] * r_m[1][29:0];
    assign sq_p[2] = r_m[2][29:0] * r_m[2][29:0];

    logic [MW-1:0] sq_t;
    assign sq_t = r_root + r_bit;

    logic [MW-1:0] div_t;
    assign div_t = {r_rem[MW-2:0], r_dv[MW-1]};

    always_comb begin
        pos_we = 1'b0; pos_wa = AW'(in_ia); pos_wd = in_pos;
        sum_we = 1'b0; sum_wa = r_idx[r_k]; sum_wd = {sat_v[2], sat_v[1], sat_v[0]};
        pos_ra = r_idx[0]; sum_ra = r_idx[r_k];
        if (r_state == S_CLR) begin
            sum_we = 1'b1; sum_wa = r_cnt[AW-1:0]; sum_wd = '0;
        end else if (r_state == S_IDLE) begin
            pos_ra = AW'(in_ia); sum_ra = AW'(in_ia);
            if (in_xfer && in_op == OP_LOAD && ok_a) begin
                pos_we = 1'b1;
                sum_we = 1'b1; sum_wa = AW'(in_ia); sum_wd = '0;
            end
        end else if (r_state == S_RDA) begin
            pos_ra = r_idx[1];
        end else if (r_state == S_RDB) begin
            pos_ra = r_idx[2];
        end else if (r_state == S_SUMWR) begin
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (out_xfer) m_axis_tvalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(MAX_VERTICES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_idx[0] <= AW'(in_ia);
                        r_idx[1] <= AW'(in_ib);
                        r_idx[2] <= AW'(in_ic);
                        r_k <= 2'd0;
                        case (in_op)
                            OP_TRI: if (ok_a && ok_b && ok_c) begin
                                r_tri <= 1'b1; r_state <= S_RDA;
                            end
                            OP_READ: begin
                                r_tri <= 1'b0;
                                r_ok <= ok_a;
                                r_state <= ok_a ? S_RDS : S_OUT;
                                for (int i = 0; i < 3; i++) r_n[i] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDS: begin
                    for (int i = 0; i < 3; i++) r_c[i] <= scomp(r_sum_q, i);
                    r_state <= S_MAG;
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    for (int i = 0; i < 3; i++) r_va[i] <= pcomp(r_pos_q, i);
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_pb <= r_pos_q;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= pcomp(r_pb, i) - r_va[i];
                        r_e2[i] <= pcomp(r_pos_q, i) - r_va[i];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p[0] <= r_e1[1] * r_e2[2]; r_p[1] <= r_e1[2] * r_e2[1];
                    r_p[2] <= r_e1[2] * r_e2[0]; r_p[3] <= r_e1[0] * r_e2[2];
                    r_p[4] <= r_e1[0] * r_e2[1]; r_p[5] <= r_e1[1] * r_e2[0];
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    for (int i = 0; i < 3; i++)
                        r_c[i] <= MW'(r_p[2*i]) - MW'(r_p[2*i+1]);
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++)
                        r_m[i] <= r_c[i][MW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
                    r_state <= S_SHFT;
                end
                S_SHFT: begin
                    if (big == '0) begin
                        r_ok <= 1'b0;
                        r_state <= r_tri ? S_IDLE : S_OUT;
                    end else if (big >= (MW'(1) << 30)) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else begin
                        r_ok <= 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq <= MW'(sq_p[0]) + MW'(sq_p[1]) + MW'(sq_p[2]);
                    r_root <= '0;
                    r_bit <= MW'(1) << 62;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_len <= (r_root == '0) ? MW'(1) : r_root;
                        r_k <= 2'd0;
                        r_dcnt <= '0;
                        r_rem <= '0;
                        r_dv <= ((r_m[0] << 14) + (((r_root == '0) ? MW'(1) : r_root) >> 1))
                                << (MW - 48);
                        r_q <= '0;
                        r_state <= S_DIV;
                    end else begin
                        if (r_sq >= sq_t) begin
                            r_sq <= r_sq - sq_t;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIV: begin
                    // Dividend fits 48 bits; quotient is built one bit a cycle.
                    if (r_dcnt == 6'd48) begin
                        r_n[r_k] <= r_c[r_k][MW-1]
                            ? -NRM_W'((r_q > 17'd16384) ? 17'd16384 : r_q)
                            :  NRM_W'((r_q > 17'd16384) ? 17'd16384 : r_q);
                        r_dcnt <= '0; r_rem <= '0; r_q <= '0;
                        if (r_k == 2'd2) begin
                            r_k <= 2'd0;
                            r_state <= r_tri ? S_SUMRD : S_OUT;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_dv <= ((r_m[r_k+1] << 14) + (r_len >> 1)) << (MW - 48);
                        end
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                        r_dv <= r_dv << 1;
                        if (div_t >= r_len) begin
                            r_rem <= div_t - r_len;
                            r_q <= {r_q[NRM_W-1:0], 1'b1};
                        end else begin
                            r_rem <= div_t;
                            r_q <= {r_q[NRM_W-1:0], 1'b0};
                        end
                    end
                end
                S_SUMRD: r_state <= S_SUMWR;
                S_SUMWR: begin
                    if (r_k == 2'd2) r_state <= S_IDLE;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_SUMRD;
                    end
                end
                S_OUT: begin
                    if (!m_axis_tvalid) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= r_ok ? {r_n[2], r_n[1], r_n[0]} : '0;
                        m_axis_tuser <= !r_ok;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_we && r_state == S_SUMWR |-> r_tri)
        else $error("sum written outside triangle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero flag with nonzero normal");
endmodule
